/* hdl/sample_variance_stddev_assert.svh */
// assertion macros for the variance block
`ifndef SAMPLE_VARIANCE_STDDEV_ASSERT_SVH
`define SAMPLE_VARIANCE_STDDEV_ASSERT_SVH

// same-cycle implication
`define SVS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sample_variance_stddev assertion failed");

// next-cycle implication
`define SVS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sample_variance_stddev assertion failed");

`endif

/* hdl/svs_pkg.sv */
package svs_pkg;

  localparam int SMP_W = 24;
  localparam int MAG_W = 24;
  localparam int SQ_W  = 48;
  localparam int SUM_W = 62;
  localparam int VAR_W = 50;
  localparam int SD_W  = 25;
  localparam int CNT_W = 13;
  localparam int ST_W  = 2;

  localparam logic [CNT_W-1:0] MAX_SAMPLES = 13'd4096;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [ST_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [ST_W-1:0] STATUS_TOO_FEW  = 2'd1;
  localparam logic [ST_W-1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    last_sample;
  } in_word_t;

  typedef struct packed {
    logic [VAR_W-1:0] variance;
    logic [SD_W-1:0]  std_dev;
    logic [CNT_W-1:0] samples_used;
    logic [ST_W-1:0]  status;
  } out_word_t;

  // one finished data set handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0] dev_sum;
    logic [CNT_W-1:0] n_used;
    logic             ovf;
  } job_t;

  typedef struct packed {
    logic           empty;
    logic [QCW-1:0] fill;
  } fifo_stat_t;

endpackage

/* hdl/svs_front.sv */
module svs_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic signed [svs_pkg::SMP_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  svs_pkg::in_word_t              in_word_i,
  output logic                           in_ready_o,
  input  svs_pkg::fifo_stat_t            fifo_stat_i,
  output logic                           push_o,
  output svs_pkg::job_t                  push_job_o
);

  logic signed [svs_pkg::SMP_W-1:0] mean_q;

  logic [svs_pkg::CNT_W-1:0] count_q, count_d, count_n;
  logic                      ovf_q, ovf_d;
  logic [svs_pkg::SUM_W-1:0] sum_q, sum_d, acc;

  logic                      add1_q, last1_q, add2_q, last2_q;
  logic [svs_pkg::MAG_W-1:0] mag_q;
  logic [svs_pkg::CNT_W-1:0] cnt1_q, cnt2_q;
  logic                      jovf1_q, jovf2_q;
  logic [svs_pkg::SQ_W-1:0]  sq_q;

  logic                      room, fire;
  logic signed [svs_pkg::SMP_W:0] diff;
  logic signed [svs_pkg::SMP_W:0] ndiff;
  logic [svs_pkg::MAG_W-1:0] mag;
  logic [svs_pkg::QCW:0]     pending;

  // sets in flight still need a queue slot
  assign pending = {1'b0, fifo_stat_i.fill} + (svs_pkg::QCW+1)'(last1_q)
                 + (svs_pkg::QCW+1)'(last2_q);
  assign in_ready_o = pending < (svs_pkg::QCW+1)'(svs_pkg::QDEPTH);
  assign fire       = in_valid_i & in_ready_o;
  assign room       = count_q < svs_pkg::MAX_SAMPLES;
  assign count_n    = room ? count_q + 1'b1 : count_q;

  assign diff  = {in_word_i.sample[svs_pkg::SMP_W-1], in_word_i.sample}
               - {mean_q[svs_pkg::SMP_W-1], mean_q};
  assign ndiff = -diff;
  assign mag   = diff[svs_pkg::SMP_W] ? ndiff[svs_pkg::MAG_W-1:0] : diff[svs_pkg::MAG_W-1:0];

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (fire) begin
      if (in_word_i.last_sample) begin
        count_d = '0;
        ovf_d   = 1'b0;
      end else begin
        count_d = count_n;
        ovf_d   = ovf_q | ~room;
      end
    end
  end

  assign acc   = sum_q + (add2_q ? {{(svs_pkg::SUM_W-svs_pkg::SQ_W){1'b0}}, sq_q} : '0);
  assign sum_d = last2_q ? '0 : acc;

  assign push_o             = last2_q;
  assign push_job_o.dev_sum = acc;
  assign push_job_o.n_used  = cnt2_q;
  assign push_job_o.ovf     = jovf2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q  <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
      sum_q   <= '0;
      add1_q  <= 1'b0;
      last1_q <= 1'b0;
      add2_q  <= 1'b0;
      last2_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mean_q <= cfg_data_i;
      end
      count_q <= count_d;
      ovf_q   <= ovf_d;
      sum_q   <= sum_d;
      add1_q  <= fire & room;
      last1_q <= fire & in_word_i.last_sample;
      add2_q  <= add1_q;
      last2_q <= last1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag;
    cnt1_q  <= count_n;
    jovf1_q <= ovf_q | ~room;
    sq_q    <= {{(svs_pkg::SQ_W-svs_pkg::MAG_W){1'b0}}, mag_q}
             * {{(svs_pkg::SQ_W-svs_pkg::MAG_W){1'b0}}, mag_q};
    cnt2_q  <= cnt1_q;
    jovf2_q <= jovf1_q;
  end

endmodule

/* hdl/svs_fifo.sv */
module svs_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  svs_pkg::job_t       job_i,
  input  logic                pop_i,
  output svs_pkg::job_t       job_o,
  output svs_pkg::fifo_stat_t stat_o
);

  svs_pkg::job_t                 mem_q [svs_pkg::QDEPTH];
  logic [svs_pkg::QAW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [svs_pkg::QCW-1:0]       fill_q, fill_d;

  assign job_o        = mem_q[rd_ptr_q];
  assign stat_o.empty = fill_q == '0;
  assign stat_o.fill  = fill_q;

  always_comb begin
    fill_d = fill_q;
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

/* hdl/svs_back.sv */
module svs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  svs_pkg::job_t      job_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output svs_pkg::out_word_t out_word_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SQRT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam int STEP_W = $clog2(svs_pkg::SUM_W);
  localparam int SREM_W = svs_pkg::SD_W;

  logic [1:0]                state_q, state_d;
  logic [STEP_W-1:0]         step_q, step_d;
  logic [svs_pkg::SUM_W-1:0] num_q, num_d;
  logic [svs_pkg::CNT_W-1:0] rem_q, rem_d, dsr_q, dsr_d, cnt_q, cnt_d;
  logic [svs_pkg::VAR_W-1:0] rad_q, rad_d;
  logic [svs_pkg::SD_W-1:0]  root_q, root_d;
  logic [SREM_W-1:0]         srem_q, srem_d;
  logic [svs_pkg::ST_W-1:0]  stat_q, stat_d;
  logic                      out_valid_q, out_valid_d;
  svs_pkg::out_word_t        out_q, out_d;

  logic [svs_pkg::CNT_W:0]   rem_sh, rem_sub;
  logic                      div_ge;
  logic [SREM_W+1:0]         srem_sh, trial, srem_sub;
  logic                      sq_ge;
  logic                      load_out;

  // restoring divide, one quotient bit a cycle
  assign rem_sh  = {rem_q, num_q[svs_pkg::SUM_W-1]};
  assign div_ge  = rem_sh >= {1'b0, dsr_q};
  assign rem_sub = rem_sh - {1'b0, dsr_q};

  // digit-by-digit root, one result bit a cycle
  assign srem_sh  = {srem_q, rad_q[svs_pkg::VAR_W-1 -: 2]};
  assign trial    = {root_q, 2'b01};
  assign sq_ge    = srem_sh >= trial;
  assign srem_sub = srem_sh - trial;

  assign load_out    = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign pop_o       = (state_q == ST_IDLE) && !empty_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    num_d       = num_q;
    rem_d       = rem_q;
    dsr_d       = dsr_q;
    cnt_d       = cnt_q;
    rad_d       = rad_q;
    root_d      = root_q;
    srem_d      = srem_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          cnt_d  = job_i.n_used;
          root_d = '0;
          step_d = '0;
          rem_d  = '0;
          if (job_i.n_used < svs_pkg::CNT_W'(2)) begin
            num_d   = '0;
            stat_d  = svs_pkg::STATUS_TOO_FEW;
            state_d = ST_DONE;
          end else begin
            num_d   = job_i.dev_sum;
            dsr_d   = job_i.n_used - 1'b1;
            stat_d  = job_i.ovf ? svs_pkg::STATUS_OVERFLOW : svs_pkg::STATUS_OK;
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_d  = div_ge ? rem_sub[svs_pkg::CNT_W-1:0] : rem_sh[svs_pkg::CNT_W-1:0];
        num_d  = {num_q[svs_pkg::SUM_W-2:0], div_ge};
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(svs_pkg::SUM_W - 1)) begin
          rad_d   = num_d[svs_pkg::VAR_W-1:0];
          srem_d  = '0;
          root_d  = '0;
          step_d  = '0;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        srem_d = sq_ge ? srem_sub[SREM_W-1:0] : srem_sh[SREM_W-1:0];
        root_d = {root_q[svs_pkg::SD_W-2:0], sq_ge};
        rad_d  = {rad_q[svs_pkg::VAR_W-3:0], 2'b00};
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(svs_pkg::SD_W - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          out_d.variance     = num_q[svs_pkg::VAR_W-1:0];
          out_d.std_dev      = root_q;
          out_d.samples_used = cnt_q;
          out_d.status       = stat_q;
          out_valid_d        = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    cnt_q  <= cnt_d;
    rad_q  <= rad_d;
    root_q <= root_d;
    srem_q <= srem_d;
    stat_q <= stat_d;
    out_q  <= out_d;
  end

endmodule

/* hdl/sample_variance_stddev.sv */
// throughput: one sample word per cycle while the queue has room; a set's closing word
// occupies the back end for a 62-step restoring divide, then a 25-step square root
// a set with fewer than two samples skips both steps and reports too few samples
// a 4-set queue lets samples of later sets flow while the back end is busy
// reset: asynchronous, active low; clears mean, accumulator, counts, queue and output valid
module sample_variance_stddev (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic signed [svs_pkg::SMP_W-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  svs_pkg::in_word_t                in_word_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output svs_pkg::out_word_t               out_word_o
);

  logic                push;
  logic                pop;
  svs_pkg::job_t       push_job;
  svs_pkg::job_t       head_job;
  svs_pkg::fifo_stat_t fifo_stat;

  assign cfg_ready_o = 1'b1;

  svs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_word_i   (in_word_i),
    .in_ready_o  (in_ready_o),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .push_job_o  (push_job)
  );

  svs_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (head_job),
    .stat_o (fifo_stat)
  );

  svs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .empty_i     (fifo_stat.empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

`include "sample_variance_stddev_assert.svh"

  `SVS_ASSERT_NOW(a_no_push_full, push, fifo_stat.fill != svs_pkg::QCW'(svs_pkg::QDEPTH))
  `SVS_ASSERT_NOW(a_no_pop_empty, pop, !fifo_stat.empty)
  `SVS_ASSERT_NOW(a_too_few_zero,
    out_valid_o && (out_word_o.status == svs_pkg::STATUS_TOO_FEW),
    (out_word_o.variance == '0) && (out_word_o.std_dev == '0))
  `SVS_ASSERT_NOW(a_count_max, out_valid_o, out_word_o.samples_used <= svs_pkg::MAX_SAMPLES)
  `SVS_ASSERT_NEXT(a_pop_advances, pop && !push,
    fifo_stat.fill == $past(fifo_stat.fill) - 1'b1)

endmodule
